// ----- rtl/core/datpm_pkg.sv -----
// Shared types, constants and helper functions of the double-array trie prefix match unit.
// Depends on nothing; every other file of the block but datpm_ram imports it.
package datpm_pkg;

	localparam int TRIE_DEPTH = 65536;
	localparam int TRIE_AW = $clog2(TRIE_DEPTH);
	localparam int UNITS_W = 17;
	localparam logic [31:0] TRIE_BOUND_MAX = 32'(TRIE_DEPTH);

	localparam logic [31:0] LABEL_MASK = 32'h8000_00FF;
	localparam logic [31:0] VALUE_MASK = 32'h7FFF_FFFF;
	localparam logic [31:0] EXT_FLAG = 32'h0000_0200;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_KEY = 1'b1;

	localparam logic REG_UNITS_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		STATUS_MATCH = 2'd0,
		STATUS_NO_MATCH = 2'd1,
		STATUS_WALK_OOB = 2'd2,
		STATUS_LEAF_OOB = 2'd3
	} status_t;

	typedef struct packed {
		logic action;
		logic [15:0] unit_addr;
		logic [31:0] unit_data;
		logic [7:0] key_byte;
		logic key_last;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [30:0] match_value;
	} res_t;

	typedef struct packed {
		logic capture;
		logic write;
		logic key_start;
		logic step;
		logic use_root;
		logic node;
		logic leaf;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic inside_key;
		logic decided;
		logic key_last;
		logic step_oob;
		logic label_ok;
		logic is_leaf;
		logic leaf_oob;
		logic out_free;
	} dp_sts_t;

	function automatic logic [31:0] unit_offset(input logic [31:0] u);
		logic [31:0] off;
		if ((u & EXT_FLAG) != 32'd0) begin
			off = {2'b00, u[31:10], 8'h00};
		end else begin
			off = {10'd0, u[31:10]};
		end
		return off;
	endfunction

endpackage

// ----- rtl/core/datpm_ram.sv -----
// Generic single-port RAM with a registered read port.
// Has no dependencies.
module datpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/core/datpm_ctrl.sv -----
// Controller state machine that sequences unit writes and the trie walk of each key byte.
// Depends on datpm_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module datpm_ctrl
	import datpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	input dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_ROOT,
		S_ROOT_STEP,
		S_STEP,
		S_NODE,
		S_LEAF,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t done_state;

	assign done_state = sts.key_last ? S_EMIT : S_IDLE;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = req_valid;
				if (req_valid) begin
					if (req.action == ACT_WRITE) begin
						state_d = S_WRITE;
					end else if (!sts.inside_key) begin
						state_d = S_ROOT;
					end else if (!sts.decided) begin
						state_d = S_STEP;
					end else if (req.key_last) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d = S_IDLE;
			end
			S_ROOT: begin
				cmd.key_start = 1'b1;
				state_d = S_ROOT_STEP;
			end
			S_ROOT_STEP, S_STEP: begin
				cmd.step = 1'b1;
				cmd.use_root = (state_q == S_ROOT_STEP);
				state_d = sts.step_oob ? done_state : S_NODE;
			end
			S_NODE: begin
				cmd.node = 1'b1;
				if (sts.label_ok && sts.is_leaf && !sts.leaf_oob) begin
					state_d = S_LEAF;
				end else begin
					state_d = done_state;
				end
			end
			S_LEAF: begin
				cmd.leaf = 1'b1;
				state_d = done_state;
			end
			S_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.write, cmd.key_start, cmd.step, cmd.node, cmd.leaf,
			cmd.emit}))
		else $error("Datapath commands overlap.");

	a_leaf_after_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEAF) |-> ($past(state_q) == S_NODE))
		else $error("Leaf read was not preceded by a node read.");

	a_root_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key_start |=> (state_q == S_ROOT_STEP))
		else $error("Root read was not followed by the first step.");

endmodule

// ----- rtl/core/datpm_dp.sv -----
// Datapath: request capture, trie memory, node position, held outcome and result register.
// Depends on datpm_pkg and datpm_ram; steered by datpm_ctrl through dp_cmd_t.
module datpm_dp
	import datpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input req_t req,
	input logic [UNITS_W-1:0] units_in_use,
	input dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic res_valid,
	input logic res_ready,
	output res_t res
);

	req_t item_q;
	logic [31:0] pos_q;
	logic inside_q;
	logic decided_q;
	status_t held_status_q;
	logic [30:0] held_value_q;
	logic res_valid_q;
	res_t res_q;

	logic [31:0] units_ext;
	logic [31:0] bound;
	logic [31:0] rdata;
	logic [31:0] base;
	logic [31:0] pos_calc;
	logic [31:0] new_pos;
	logic ram_we;
	logic [TRIE_AW-1:0] ram_addr;

	assign units_ext = 32'(units_in_use);
	assign bound = (units_ext > TRIE_BOUND_MAX) ? TRIE_BOUND_MAX : units_ext;

	assign base = cmd.use_root ? unit_offset(rdata) : pos_q;
	assign pos_calc = base ^ {24'd0, item_q.key_byte};
	assign new_pos = pos_q ^ unit_offset(rdata);

	assign sts.inside_key = inside_q;
	assign sts.decided = decided_q;
	assign sts.key_last = item_q.key_last;
	assign sts.step_oob = (pos_calc >= bound);
	assign sts.label_ok = ((rdata & LABEL_MASK) == {24'd0, item_q.key_byte});
	assign sts.is_leaf = rdata[8];
	assign sts.leaf_oob = (new_pos >= bound);
	assign sts.out_free = !res_valid_q || res_ready;

	assign ram_we = cmd.write && (32'(item_q.unit_addr) < TRIE_BOUND_MAX);

	always_comb begin
		if (cmd.write) begin
			ram_addr = TRIE_AW'(item_q.unit_addr);
		end else if (cmd.key_start) begin
			ram_addr = '0;
		end else if (cmd.step) begin
			ram_addr = pos_calc[TRIE_AW-1:0];
		end else begin
			ram_addr = new_pos[TRIE_AW-1:0];
		end
	end

	datpm_ram #(
		.WIDTH(32),
		.DEPTH(TRIE_DEPTH)
	) u_trie_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(item_q.unit_data),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.step) begin
			pos_q <= pos_calc;
		end else if (cmd.node && sts.label_ok) begin
			pos_q <= new_pos;
		end
		if (cmd.emit) begin
			res_q.status <= held_status_q;
			res_q.match_value <= (held_status_q == STATUS_MATCH) ? held_value_q : 31'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			decided_q <= 1'b0;
			held_status_q <= STATUS_NO_MATCH;
			held_value_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.key_start) begin
				inside_q <= 1'b1;
				decided_q <= 1'b0;
				held_status_q <= STATUS_NO_MATCH;
				held_value_q <= '0;
			end else if (cmd.step && sts.step_oob) begin
				decided_q <= 1'b1;
				held_status_q <= STATUS_WALK_OOB;
				held_value_q <= '0;
			end else if (cmd.node && !sts.label_ok) begin
				decided_q <= 1'b1;
				held_status_q <= STATUS_NO_MATCH;
				held_value_q <= '0;
			end else if (cmd.node && sts.is_leaf && sts.leaf_oob) begin
				decided_q <= 1'b1;
				held_status_q <= STATUS_LEAF_OOB;
				held_value_q <= '0;
			end else if (cmd.leaf) begin
				decided_q <= 1'b1;
				held_status_q <= STATUS_MATCH;
				held_value_q <= rdata[30:0];
			end else if (cmd.emit) begin
				inside_q <= 1'b0;
				decided_q <= 1'b0;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_emit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (res_valid_q && !inside_q && !decided_q))
		else $error("Result was not presented after an emit.");

	a_decided_inside_key: assert property (@(posedge clk) disable iff (!arst_n)
		decided_q |-> inside_q)
		else $error("Outcome is decided outside of a key.");

	a_value_only_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		(held_value_q != 31'd0) |-> (held_status_q == STATUS_MATCH))
		else $error("A value is held without a match.");

endmodule

// ----- rtl/core/double_array_trie_prefix_match_unit.sv -----
// Double-array trie prefix match unit: configuration register, controller and datapath.
// Depends on datpm_pkg, datpm_ctrl, datpm_dp and datpm_ram.
// A unit write goes through S_WRITE. A key byte takes a step and a node read, plus a leaf read on a leaf,
// the step alone if out of bounds, its capture alone once decided; a root read starts a key, a result load ends it.
// The rate is set by the chain of dependent reads on the single trie RAM port.
// Reset clears the walk state and sets units_in_use to 1; the trie RAM is not cleared.
module double_array_trie_prefix_match_unit
	import datpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic res_valid,
	input logic res_ready,
	output res_t res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [UNITS_W-1:0] units_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= UNITS_W'(1);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_UNITS_IN_USE)) begin
			units_q <= pwdata[UNITS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_UNITS_IN_USE) ? 32'(units_q) : 32'd0;

	datpm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.sts(sts),
		.cmd(cmd)
	);

	datpm_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.units_in_use(units_q),
		.cmd(cmd),
		.sts(sts),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule
